// ===== hdl/rsch_pkg.sv =====
// Package for the ray/segment closest-hit block: field widths, input codes,
// state encodings and the lane record that flows down the divider chain.
// No dependencies.
package rsch_pkg;

	localparam int COORD_W = 16;
	localparam int DIR_W   = 17;
	localparam int PROD_W  = 34;
	localparam int SUM_W   = 35;
	localparam int MAG_W   = 34;
	localparam int TQ_W    = 17;
	localparam int OUT_W   = 24;
	localparam int MODE_W  = 2;
	localparam int SEG_W   = 64;
	localparam int IN_DATA_W  = 64;
	localparam int OUT_DATA_W = 72;
	localparam int OUT_MAX = 8388607;
	localparam int OUT_MIN = -8388608;

	localparam logic [MODE_W-1:0] MODE_CLEAR = 2'd0;
	localparam logic [MODE_W-1:0] MODE_LOAD  = 2'd1;
	localparam logic [MODE_W-1:0] MODE_CAST  = 2'd2;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN,
		ST_LAUNCH,
		ST_POINT,
		ST_FIN
	} state_t;

	typedef enum logic [2:0] {
		PT_IDLE,
		PT_MUL,
		PT_INIT,
		PT_DIV,
		PT_SAT
	} pt_state_t;

	// Segment word as stored; ax sits in the lowest bits.
	typedef struct packed {
		logic [COORD_W-1:0] by;
		logic [COORD_W-1:0] bx;
		logic [COORD_W-1:0] ay;
		logic [COORD_W-1:0] ax;
	} seg_t;

	// One segment's candidate hit as it moves through the divider cells.
	typedef struct packed {
		logic             valid;
		logic             last;
		logic             ok;
		logic [MAG_W-1:0] tn;
		logic [MAG_W-1:0] den;
		logic [MAG_W-1:0] rem;
		logic [TQ_W-1:0]  q;
	} lane_t;

endpackage

// ===== hdl/rsch_div_cell.sv =====
// One cell of the T divider chain: settles one quotient bit of tn*2^16/den.
// Depends on rsch_pkg.
module rsch_div_cell (
	input  logic            clk,
	input  logic            arst_n,
	input  rsch_pkg::lane_t lane_in,
	output rsch_pkg::lane_t lane_out
);

	logic                       ge;
	logic [rsch_pkg::MAG_W-1:0] rem_n;
	logic                       valid_q;
	rsch_pkg::lane_t            data_n;
	rsch_pkg::lane_t            data_q;

	// The remainder stays below den, so doubling it cannot overflow.
	always_comb begin
		ge         = lane_in.rem >= lane_in.den;
		rem_n      = ge ? (lane_in.rem - lane_in.den) : lane_in.rem;
		data_n     = lane_in;
		data_n.rem = {rem_n[rsch_pkg::MAG_W-2:0], 1'b0};
		data_n.q   = {lane_in.q[rsch_pkg::TQ_W-2:0], ge};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else begin
			valid_q <= lane_in.valid;
		end
	end

	always_ff @(posedge clk) begin
		data_q <= data_n;
	end

	always_comb begin
		lane_out       = data_q;
		lane_out.valid = valid_q;
	end

endmodule

// ===== hdl/rsch_geom.sv =====
// Cross-product pipeline: turns one stored segment and the current ray into
// den, tn and un, normalizes the sign and applies the hit window tests.
// Depends on rsch_pkg.
module rsch_geom (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               in_valid,
	input  logic                               in_last,
	input  rsch_pkg::seg_t                     seg,
	input  logic signed [rsch_pkg::COORD_W-1:0] org_x,
	input  logic signed [rsch_pkg::COORD_W-1:0] org_y,
	input  logic signed [rsch_pkg::DIR_W-1:0]   dir_x,
	input  logic signed [rsch_pkg::DIR_W-1:0]   dir_y,
	output rsch_pkg::lane_t                    lane
);

	logic valid_s2, valid_s3, valid_s4, valid_s5, valid_s6;
	logic last_s2, last_s3, last_s4, last_s5;

	logic signed [rsch_pkg::DIR_W-1:0] sdx_s2, sdy_s2, wx_s2, wy_s2;
	logic signed [rsch_pkg::PROD_W-1:0] pda_s3, pdb_s3, pta_s3, ptb_s3, pua_s3, pub_s3;
	logic signed [rsch_pkg::SUM_W-1:0] den_s4, tn_s4, un_s4;
	logic signed [rsch_pkg::SUM_W-1:0] den_s5, tn_s5, un_s5;
	logic zero_s5;
	logic neg;
	logic ok;
	logic [rsch_pkg::SUM_W-1:0] den2;
	rsch_pkg::lane_t data_s6;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
			valid_s5 <= 1'b0;
			valid_s6 <= 1'b0;
		end else begin
			valid_s2 <= in_valid;
			valid_s3 <= valid_s2;
			valid_s4 <= valid_s3;
			valid_s5 <= valid_s4;
			valid_s6 <= valid_s5;
		end
	end

	always_comb begin
		neg  = den_s4[rsch_pkg::SUM_W-1];
		den2 = {den_s5[rsch_pkg::SUM_W-2:0], 1'b0};
		ok   = !zero_s5 && !tn_s5[rsch_pkg::SUM_W-1] && !un_s5[rsch_pkg::SUM_W-1]
			&& ($unsigned(un_s5) <= $unsigned(den_s5))
			&& ($unsigned(tn_s5) < den2);
	end

	always_ff @(posedge clk) begin
		last_s2 <= in_last;
		sdx_s2  <= $signed({seg.bx[15], seg.bx}) - $signed({seg.ax[15], seg.ax});
		sdy_s2  <= $signed({seg.by[15], seg.by}) - $signed({seg.ay[15], seg.ay});
		wx_s2   <= $signed({seg.ax[15], seg.ax}) - $signed({org_x[15], org_x});
		wy_s2   <= $signed({seg.ay[15], seg.ay}) - $signed({org_y[15], org_y});

		last_s3 <= last_s2;
		pda_s3  <= sdx_s2 * dir_y;
		pdb_s3  <= sdy_s2 * dir_x;
		pta_s3  <= sdx_s2 * wy_s2;
		ptb_s3  <= sdy_s2 * wx_s2;
		pua_s3  <= dir_x * wy_s2;
		pub_s3  <= dir_y * wx_s2;

		last_s4 <= last_s3;
		den_s4  <= rsch_pkg::SUM_W'(pda_s3) - rsch_pkg::SUM_W'(pdb_s3);
		tn_s4   <= rsch_pkg::SUM_W'(pta_s3) - rsch_pkg::SUM_W'(ptb_s3);
		un_s4   <= rsch_pkg::SUM_W'(pua_s3) - rsch_pkg::SUM_W'(pub_s3);

		// Flip all three signs together so that den is never negative.
		last_s5 <= last_s4;
		zero_s5 <= den_s4 == '0;
		den_s5  <= neg ? -den_s4 : den_s4;
		tn_s5   <= neg ? -tn_s4 : tn_s4;
		un_s5   <= neg ? -un_s4 : un_s4;

		data_s6.valid <= 1'b0;
		data_s6.last  <= last_s5;
		data_s6.ok    <= ok;
		data_s6.tn    <= tn_s5[rsch_pkg::MAG_W-1:0];
		data_s6.den   <= den_s5[rsch_pkg::MAG_W-1:0];
		data_s6.rem   <= tn_s5[rsch_pkg::MAG_W-1:0];
		data_s6.q     <= '0;
	end

	always_comb begin
		lane       = data_s6;
		lane.valid = valid_s6;
	end

endmodule

// ===== hdl/rsch_point.sv =====
// Hit point unit: origin*2^F plus or minus floor(|dir|*tn*2^F/den), found
// by a bit-serial restoring divider, then saturated to 24 bits.
// Depends on rsch_pkg.
module rsch_point #(
	parameter int FRAC_BITS = 8
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                start,
	input  logic signed [rsch_pkg::COORD_W-1:0] origin,
	input  logic signed [rsch_pkg::DIR_W-1:0]   dir,
	input  logic [rsch_pkg::MAG_W-1:0]          tn,
	input  logic [rsch_pkg::MAG_W-1:0]          den,
	output logic                                done,
	output logic signed [rsch_pkg::OUT_W-1:0]   coord
);

	localparam int QW    = rsch_pkg::TQ_W + FRAC_BITS;
	localparam int CW    = $clog2(QW);
	localparam int PW    = rsch_pkg::COORD_W + rsch_pkg::MAG_W;
	localparam int VW    = (QW + 2 > rsch_pkg::OUT_W + 1) ? QW + 2 : rsch_pkg::OUT_W + 1;
	localparam logic signed [VW-1:0] V_MAX = VW'(rsch_pkg::OUT_MAX);
	localparam logic signed [VW-1:0] V_MIN = VW'(rsch_pkg::OUT_MIN);

	rsch_pkg::pt_state_t st_q, st_n;

	logic                                neg_q;
	logic [rsch_pkg::COORD_W-1:0]        mag_q;
	logic signed [rsch_pkg::COORD_W-1:0] org_q;
	logic [rsch_pkg::MAG_W-1:0]          tn_q, den_q, rem_q;
	logic [PW-1:0]                       prod_q;
	logic [QW-1:0]                       bits_q, quo_q;
	logic [CW-1:0]                       cnt_q;
	logic                                done_q;
	logic signed [rsch_pkg::OUT_W-1:0]   coord_q;

	logic signed [rsch_pkg::DIR_W-1:0]   dir_abs;
	logic [rsch_pkg::MAG_W-1:0]          r2;
	logic                                ge;
	logic signed [VW-1:0]                base, off, v;
	logic signed [rsch_pkg::OUT_W-1:0]   sat;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q   <= rsch_pkg::PT_IDLE;
			done_q <= 1'b0;
		end else begin
			st_q   <= st_n;
			done_q <= st_q == rsch_pkg::PT_SAT;
		end
	end

	always_comb begin
		st_n = st_q;
		unique case (st_q)
			rsch_pkg::PT_IDLE: if (start) st_n = rsch_pkg::PT_MUL;
			rsch_pkg::PT_MUL:  st_n = rsch_pkg::PT_INIT;
			rsch_pkg::PT_INIT: st_n = rsch_pkg::PT_DIV;
			rsch_pkg::PT_DIV:  if (cnt_q == CW'(QW - 1)) st_n = rsch_pkg::PT_SAT;
			rsch_pkg::PT_SAT:  st_n = rsch_pkg::PT_IDLE;
			default:           st_n = rsch_pkg::PT_IDLE;
		endcase
	end

	always_comb begin
		dir_abs = dir[rsch_pkg::DIR_W-1] ? -dir : dir;
		r2      = {rem_q[rsch_pkg::MAG_W-2:0], bits_q[QW-1]};
		ge      = r2 >= den_q;
		base    = VW'(org_q) <<< FRAC_BITS;
		off     = $signed(VW'(quo_q));
		v       = neg_q ? (base - off) : (base + off);
		if (v > V_MAX) begin
			sat = rsch_pkg::OUT_W'(rsch_pkg::OUT_MAX);
		end else if (v < V_MIN) begin
			sat = rsch_pkg::OUT_W'(rsch_pkg::OUT_MIN);
		end else begin
			sat = v[rsch_pkg::OUT_W-1:0];
		end
	end

	// The quotient is below 2^QW, so the top part of the product can seed
	// the remainder and only QW dividend bits remain to be shifted in.
	always_ff @(posedge clk) begin
		unique case (st_q)
			rsch_pkg::PT_IDLE: begin
				neg_q <= dir[rsch_pkg::DIR_W-1];
				mag_q <= dir_abs[rsch_pkg::COORD_W-1:0];
				org_q <= origin;
				tn_q  <= tn;
				den_q <= den;
			end
			rsch_pkg::PT_MUL: begin
				prod_q <= PW'(mag_q) * PW'(tn_q);
			end
			rsch_pkg::PT_INIT: begin
				rem_q  <= {1'b0, prod_q[PW-1:rsch_pkg::TQ_W]};
				bits_q <= QW'(prod_q[rsch_pkg::TQ_W-1:0]) << FRAC_BITS;
				cnt_q  <= '0;
			end
			rsch_pkg::PT_DIV: begin
				rem_q  <= ge ? (r2 - den_q) : r2;
				bits_q <= bits_q << 1;
				quo_q  <= {quo_q[QW-2:0], ge};
				cnt_q  <= cnt_q + CW'(1);
			end
			rsch_pkg::PT_SAT: begin
				coord_q <= sat;
			end
			default: begin
				coord_q <= coord_q;
			end
		endcase
	end

	assign done  = done_q;
	assign coord = coord_q;

endmodule

// ===== hdl/ray_segment_closest_hit.sv =====
// Top level of the ray/segment closest-hit block: segment memory, scan
// sequencer, divider cell chain, closest-hit selection and output register.
// Depends on rsch_pkg, rsch_geom, rsch_div_cell and rsch_point.
//
// Usage: items enter on the s_ channel. s_tuser carries the mode: clear the
// table, load one segment (a at the low end, b above), or cast a ray from a
// toward b. Clear and load give no result. A cast gives one result on the
// m_ channel: hit flag in m_tuser, hit x, hit y and T in m_tdata. A cast over
// N stored segments streams the segments out of the memory at one per read
// port cycle through a row of 17 divider cells, one quotient bit of T per
// cell, and then, on a hit, runs the hit point through two bit-serial dividers
// of 17 + FRAC_BITS steps. One item is in work at a time; s_tready is high
// only between items. The result sits in an output register, so the next item
// is taken while it waits; a cast that finishes while m_tready is low holds
// until the register is free. Reset empties the table and drops any pending
// result.
module ray_segment_closest_hit #(
	parameter int MAX_SEGMENTS = 64,
	parameter int FRAC_BITS    = 8
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_tvalid,
	output logic                              s_tready,
	input  logic [rsch_pkg::IN_DATA_W-1:0]    s_tdata,  // ax, ay, bx, by
	input  logic [rsch_pkg::MODE_W-1:0]       s_tuser,  // mode
	output logic                              m_tvalid,
	input  logic                              m_tready,
	output logic [rsch_pkg::OUT_DATA_W-1:0]   m_tdata,  // hit_x, hit_y, hit_t, zero pad
	output logic                              m_tuser   // hit
);

	localparam int CNT_W = $clog2(MAX_SEGMENTS + 1);
	localparam int AW    = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1;
	localparam int PAD_W = rsch_pkg::OUT_DATA_W - 2 * rsch_pkg::OUT_W - rsch_pkg::TQ_W;

	rsch_pkg::state_t state_q, state_n;

	logic [rsch_pkg::SEG_W-1:0] seg_mem [MAX_SEGMENTS];
	logic [rsch_pkg::SEG_W-1:0] rd_s1;
	logic                       valid_s1, last_s1;

	logic [CNT_W-1:0] count_q, idx_q;
	logic             accept, issue, issue_last, start, out_load;
	logic             is_cast, load_we;

	logic signed [rsch_pkg::COORD_W-1:0] org_x_q, org_y_q;
	logic signed [rsch_pkg::DIR_W-1:0]   dir_x_q, dir_y_q;

	rsch_pkg::lane_t chain [rsch_pkg::TQ_W+1];
	rsch_pkg::lane_t lane_end;

	logic                       found_q;
	logic [rsch_pkg::TQ_W-1:0]  best_t_q;
	logic [rsch_pkg::MAG_W-1:0] best_tn_q, best_den_q;
	logic                       take;

	logic                              pt_done_x, pt_done_y;
	logic signed [rsch_pkg::OUT_W-1:0] x_coord, y_coord;

	logic                         m_tvalid_q, hit_q;
	logic [rsch_pkg::OUT_W-1:0]   hit_x_q, hit_y_q;
	logic [rsch_pkg::TQ_W-1:0]    hit_t_q;

	assign accept   = s_tvalid && s_tready;
	assign is_cast  = s_tuser == rsch_pkg::MODE_CAST;
	assign load_we  = accept && (s_tuser == rsch_pkg::MODE_LOAD)
		&& (count_q != CNT_W'(MAX_SEGMENTS));
	assign lane_end = chain[rsch_pkg::TQ_W];
	assign take     = lane_end.valid && lane_end.ok && (!found_q || (lane_end.q < best_t_q));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= rsch_pkg::ST_IDLE;
		end else begin
			state_q <= state_n;
		end
	end

	always_comb begin
		state_n    = state_q;
		s_tready   = 1'b0;
		issue      = 1'b0;
		issue_last = 1'b0;
		start      = 1'b0;
		out_load   = 1'b0;
		unique case (state_q)
			rsch_pkg::ST_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid && is_cast) begin
					state_n = (count_q == '0) ? rsch_pkg::ST_FIN : rsch_pkg::ST_SCAN;
				end
			end
			rsch_pkg::ST_SCAN: begin
				issue      = idx_q != count_q;
				issue_last = idx_q == (count_q - CNT_W'(1));
				if (lane_end.valid && lane_end.last) state_n = rsch_pkg::ST_LAUNCH;
			end
			rsch_pkg::ST_LAUNCH: begin
				start   = found_q;
				state_n = found_q ? rsch_pkg::ST_POINT : rsch_pkg::ST_FIN;
			end
			rsch_pkg::ST_POINT: begin
				if (pt_done_x) state_n = rsch_pkg::ST_FIN;
			end
			rsch_pkg::ST_FIN: begin
				if (!m_tvalid_q || m_tready) begin
					out_load = 1'b1;
					state_n  = rsch_pkg::ST_IDLE;
				end
			end
			default: state_n = rsch_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q    <= '0;
			idx_q      <= '0;
			valid_s1   <= 1'b0;
			found_q    <= 1'b0;
			m_tvalid_q <= 1'b0;
		end else begin
			if (accept && s_tuser == rsch_pkg::MODE_CLEAR) begin
				count_q <= '0;
			end else if (load_we) begin
				count_q <= count_q + CNT_W'(1);
			end
			if (accept && is_cast) begin
				idx_q <= '0;
			end else if (issue) begin
				idx_q <= idx_q + CNT_W'(1);
			end
			valid_s1 <= issue;
			if (accept && is_cast) begin
				found_q <= 1'b0;
			end else if (take) begin
				found_q <= 1'b1;
			end
			if (out_load) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load_we) begin
			seg_mem[count_q[AW-1:0]] <= s_tdata[rsch_pkg::SEG_W-1:0];
		end
		rd_s1   <= seg_mem[idx_q[AW-1:0]];
		last_s1 <= issue_last;
	end

	always_ff @(posedge clk) begin
		if (accept && is_cast) begin
			org_x_q <= $signed(s_tdata[15:0]);
			org_y_q <= $signed(s_tdata[31:16]);
			dir_x_q <= $signed({s_tdata[47], s_tdata[47:32]}) - $signed({s_tdata[15], s_tdata[15:0]});
			dir_y_q <= $signed({s_tdata[63], s_tdata[63:48]}) - $signed({s_tdata[31], s_tdata[31:16]});
		end
		// Strict less-than keeps the earlier segment on equal T.
		if (take) begin
			best_t_q   <= lane_end.q;
			best_tn_q  <= lane_end.tn;
			best_den_q <= lane_end.den;
		end
		if (out_load) begin
			hit_q   <= found_q;
			hit_x_q <= found_q ? x_coord : '0;
			hit_y_q <= found_q ? y_coord : '0;
			hit_t_q <= found_q ? best_t_q : '0;
		end
	end

	rsch_geom u_geom (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (valid_s1),
		.in_last  (last_s1),
		.seg      (rsch_pkg::seg_t'(rd_s1)),
		.org_x    (org_x_q),
		.org_y    (org_y_q),
		.dir_x    (dir_x_q),
		.dir_y    (dir_y_q),
		.lane     (chain[0])
	);

	for (genvar k = 0; k < rsch_pkg::TQ_W; k++) begin : g_cell
		rsch_div_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.lane_in  (chain[k]),
			.lane_out (chain[k+1])
		);
	end

	rsch_point #(.FRAC_BITS(FRAC_BITS)) u_point_x (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.origin (org_x_q),
		.dir    (dir_x_q),
		.tn     (best_tn_q),
		.den    (best_den_q),
		.done   (pt_done_x),
		.coord  (x_coord)
	);

	rsch_point #(.FRAC_BITS(FRAC_BITS)) u_point_y (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.origin (org_y_q),
		.dir    (dir_y_q),
		.tn     (best_tn_q),
		.den    (best_den_q),
		.done   (pt_done_y),
		.coord  (y_coord)
	);

	assign m_tvalid = m_tvalid_q;
	assign m_tuser  = hit_q;
	assign m_tdata  = {PAD_W'(0), hit_t_q, hit_y_q, hit_x_q};

	a_miss_is_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tuser |-> m_tdata == '0)
		else $error("miss result carries nonzero data");

	a_point_lockstep: assert property (@(posedge clk) disable iff (!arst_n)
		pt_done_x == pt_done_y)
		else $error("point units out of step");

	a_lane_in_scan: assert property (@(posedge clk) disable iff (!arst_n)
		lane_end.valid |-> state_q == rsch_pkg::ST_SCAN)
		else $error("segment left the divider chain outside a scan");

	a_full_load: assert property (@(posedge clk) disable iff (!arst_n)
		accept && s_tuser == rsch_pkg::MODE_LOAD && count_q == CNT_W'(MAX_SEGMENTS)
		|=> count_q == $past(count_q))
		else $error("load into a full table changed the count");

endmodule

// ===== dv/ray_segment_closest_hit_chk.sv =====
// Checker for the ray/segment closest-hit block: watches both stream channels,
// keeps its own segment table and predicts the result of every cast.
// Depends on rsch_pkg for widths and mode codes.
module ray_segment_closest_hit_chk #(
	parameter int MAX_SEGMENTS = 64,
	parameter int FRAC_BITS    = 8
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_tvalid,
	input  logic                              s_tready,
	input  logic [rsch_pkg::IN_DATA_W-1:0]    s_tdata,  // ax, ay, bx, by
	input  logic [rsch_pkg::MODE_W-1:0]       s_tuser,  // mode
	input  logic                              m_tvalid,
	input  logic                              m_tready,
	input  logic [rsch_pkg::OUT_DATA_W-1:0]   m_tdata,  // hit_x, hit_y, hit_t, zero pad
	input  logic                              m_tuser,  // hit
	output int                                fails,
	output int                                pending,
	output int                                casts,
	output int                                hits
);

	typedef struct packed {
		logic                           hit;
		logic [rsch_pkg::OUT_W-1:0]     hx;
		logic [rsch_pkg::OUT_W-1:0]     hy;
		logic [rsch_pkg::TQ_W-1:0]      ht;
	} hit_rec_t;

	longint seg_ax[MAX_SEGMENTS];
	longint seg_ay[MAX_SEGMENTS];
	longint seg_bx[MAX_SEGMENTS];
	longint seg_by[MAX_SEGMENTS];
	int     seg_count;
	hit_rec_t hit_queue[$];

	// Origin plus the truncated offset along the ray, saturated to the output range.
	function automatic longint hit_coord(longint origin, longint dir, longint num, longint den);
		longint mag, p, q, r, off, v;
		mag = (dir < 0) ? -dir : dir;
		p = mag * num;
		q = p / den;
		r = p % den;
		off = (q << FRAC_BITS) + ((r << FRAC_BITS) / den);
		v = origin * (longint'(1) << FRAC_BITS);
		v = (dir < 0) ? v - off : v + off;
		if (v > rsch_pkg::OUT_MAX) v = rsch_pkg::OUT_MAX;
		if (v < rsch_pkg::OUT_MIN) v = rsch_pkg::OUT_MIN;
		return v;
	endfunction

	function automatic hit_rec_t closest_hit(longint ax, longint ay, longint bx, longint by);
		hit_rec_t res;
		longint rdx, rdy, sdx, sdy, wx, wy, den, tn, un, tq, best_t, best_n, best_d;
		longint hx, hy;
		bit found;
		rdx = bx - ax;
		rdy = by - ay;
		found = 0;
		best_t = 0;
		best_n = 0;
		best_d = 1;
		res = '0;
		for (int i = 0; i < seg_count; i++) begin
			sdx = seg_bx[i] - seg_ax[i];
			sdy = seg_by[i] - seg_ay[i];
			wx = seg_ax[i] - ax;
			wy = seg_ay[i] - ay;
			den = sdx * rdy - sdy * rdx;
			tn = sdx * wy - sdy * wx;
			un = rdx * wy - rdy * wx;
			if (den == 0) continue;
			if (den < 0) begin
				den = -den;
				tn = -tn;
				un = -un;
			end
			if (tn < 0 || un < 0 || un > den || tn >= 2 * den) continue;
			tq = (tn << 16) / den;
			// Strictly smaller keeps the earlier segment on a tie.
			if (!found || tq < best_t) begin
				found = 1;
				best_t = tq;
				best_n = tn;
				best_d = den;
			end
		end
		if (found) begin
			hx = hit_coord(ax, rdx, best_n, best_d);
			hy = hit_coord(ay, rdy, best_n, best_d);
			res.hit = 1'b1;
			res.hx = hx[rsch_pkg::OUT_W-1:0];
			res.hy = hy[rsch_pkg::OUT_W-1:0];
			res.ht = best_t[rsch_pkg::TQ_W-1:0];
		end
		return res;
	endfunction

	assign pending = hit_queue.size();

	always @(posedge clk or negedge arst_n) begin
		hit_rec_t want, got;
		longint ax, ay, bx, by;
		if (!arst_n) begin
			seg_count <= 0;
			fails <= 0;
			casts <= 0;
			hits <= 0;
			hit_queue.delete();
		end else begin
			if (s_tvalid && s_tready) begin
				ax = longint'($signed(s_tdata[15:0]));
				ay = longint'($signed(s_tdata[31:16]));
				bx = longint'($signed(s_tdata[47:32]));
				by = longint'($signed(s_tdata[63:48]));
				case (s_tuser)
					rsch_pkg::MODE_CLEAR: seg_count <= 0;
					rsch_pkg::MODE_LOAD: begin
						if (seg_count < MAX_SEGMENTS) begin
							seg_ax[seg_count] = ax;
							seg_ay[seg_count] = ay;
							seg_bx[seg_count] = bx;
							seg_by[seg_count] = by;
							seg_count <= seg_count + 1;
						end
					end
					rsch_pkg::MODE_CAST: begin
						want = closest_hit(ax, ay, bx, by);
						hit_queue = {hit_queue, want};
						casts <= casts + 1;
						if (want.hit) hits <= hits + 1;
					end
					default: ;
				endcase
			end
			if (m_tvalid && m_tready) begin
				got.hit = m_tuser;
				got.hx = m_tdata[23:0];
				got.hy = m_tdata[47:24];
				got.ht = m_tdata[64:48];
				if (hit_queue.size() == 0) begin
					$display("%0t: unexpected result hit=%0d x=%h y=%h t=%h", $time,
						got.hit, got.hx, got.hy, got.ht);
					fails <= fails + 1;
				end else begin
					want = hit_queue.pop_front();
					if (got !== want || m_tdata[71:65] !== '0) begin
						$display("%0t: mismatch expected hit=%0d x=%h y=%h t=%h", $time,
							want.hit, want.hx, want.hy, want.ht);
						$display("%0t:          actual   hit=%0d x=%h y=%h t=%h pad=%h", $time,
							got.hit, got.hx, got.hy, got.ht, m_tdata[71:65]);
						fails <= fails + 1;
					end
				end
			end
		end
	end

endmodule

// ===== dv/ray_segment_closest_hit_tb.sv =====
// Testbench top for the ray/segment closest-hit block: clock, reset, directed
// and random segment loads and ray casts, output back-pressure and verdict.
// Depends on rsch_pkg, ray_segment_closest_hit and ray_segment_closest_hit_chk.
module ray_segment_closest_hit_tb;

	localparam logic [rsch_pkg::MODE_W-1:0] MODE_UNUSED = 2'd3;
	localparam int CYCLE_LIMIT = 2000000;
	localparam int HOLD_OFF_CYCLES = 400;

	logic                              clk;
	logic                              arst_n;
	logic                              s_tvalid;
	logic                              s_tready;
	logic [rsch_pkg::IN_DATA_W-1:0]    s_tdata;
	logic [rsch_pkg::MODE_W-1:0]       s_tuser;
	logic                              m_tvalid;
	logic                              m_tready;
	logic [rsch_pkg::OUT_DATA_W-1:0]   m_tdata;
	logic                              m_tuser;
	int fails, pending, casts, hits;
	int cycles;
	int loads;

	ray_segment_closest_hit dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
	);

	ray_segment_closest_hit_chk chk (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
		.fails(fails), .pending(pending), .casts(casts), .hits(hits)
	);

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycles);
			$display("FAILURE");
			$finish;
		end
	end

	function automatic int gap_len();
		int k;
		k = $urandom_range(0, 99);
		if (k < 55) return 0;
		if (k < 90) return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	// Mostly a small window so that rays meet segments, sometimes the full range.
	function automatic int coord();
		if ($urandom_range(0, 9) < 7) return int'($urandom_range(0, 400)) - 200;
		return int'($signed(16'($urandom)));
	endfunction

	// Output side: random stalls, plus one long hold-off once enough casts went by.
	initial begin
		bit held;
		held = 0;
		m_tready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (!held && casts > 150) begin
				held = 1;
				m_tready <= 1'b0;
				for (int i = 0; i < HOLD_OFF_CYCLES; i++) @(negedge clk);
			end else if ($urandom_range(0, 3) == 0) begin
				m_tready <= 1'b0;
				repeat (gap_len()) @(negedge clk);
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	task automatic send(logic [rsch_pkg::MODE_W-1:0] mode, int ax, int ay, int bx, int by);
		int g;
		s_tvalid <= 1'b1;
		s_tuser <= mode;
		s_tdata <= {16'(by), 16'(bx), 16'(ay), 16'(ax)};
		if (mode == rsch_pkg::MODE_LOAD) loads++;
		do @(posedge clk); while (!s_tready);
		@(negedge clk);
		g = gap_len();
		if (g > 0) begin
			s_tvalid <= 1'b0;
			repeat (g) @(negedge clk);
		end
	endtask

	task automatic random_ray();
		send(rsch_pkg::MODE_CAST, coord(), coord(), coord(), coord());
	endtask

	initial begin
		int nseg, ncast;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = rsch_pkg::MODE_CLEAR;
		arst_n = 1'b0;
		loads = 0;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Directed part.
		send(rsch_pkg::MODE_CLEAR, 0, 0, 0, 0);
		send(rsch_pkg::MODE_CAST, 0, 0, 100, 0);                 // empty table, no hit
		send(rsch_pkg::MODE_LOAD, -32768, -32768, 32767, 32767);  // full-range diagonal
		send(rsch_pkg::MODE_LOAD, 5, 5, 5, 5);                   // zero-length segment
		send(rsch_pkg::MODE_LOAD, 32767, -32768, 32767, 32767);   // vertical at the right edge
		send(rsch_pkg::MODE_CAST, -32768, 0, 32767, 0);           // crosses diagonal and edge
		send(rsch_pkg::MODE_CAST, 32767, -32768, -32768, 32767);
		send(rsch_pkg::MODE_CAST, 0, 0, 0, 0);                   // zero-length ray
		send(rsch_pkg::MODE_CAST, 0, 10, 100, 110);              // parallel to the diagonal
		send(rsch_pkg::MODE_CLEAR, 0, 0, 0, 0);
		send(rsch_pkg::MODE_LOAD, 20, -10, 20, 10);              // exactly at T equal to two
		send(rsch_pkg::MODE_LOAD, 19, 0, 19, 10);                // touched at its start point
		send(rsch_pkg::MODE_LOAD, 15, -10, 15, 0);               // touched at its end point
		send(rsch_pkg::MODE_CAST, 0, 0, 10, 0);
		send(rsch_pkg::MODE_LOAD, 15, -10, 15, 0);               // duplicate, tie on T
		send(rsch_pkg::MODE_LOAD, 30, -5, 30, 5);                // beyond T of two
		send(rsch_pkg::MODE_CAST, 0, 0, 10, 0);
		send(rsch_pkg::MODE_CAST, 10, 0, 0, 0);                  // pointing away, T negative
		send(MODE_UNUSED, -1, -1, -1, -1);
		send(rsch_pkg::MODE_CAST, 0, 0, 10, 0);
		send(rsch_pkg::MODE_CAST, -1, 3, 7, -3);

		// Random part: mostly clear, load a batch, cast several rays; some noise.
		while (loads + casts < 900) begin
			if (casts > 400 && casts < 410) begin
				s_tvalid <= 1'b0;
				wait (pending == 0);
				@(negedge clk);
			end
			if ($urandom_range(0, 9) < 8)
				send(rsch_pkg::MODE_CLEAR, int'($urandom), int'($urandom), 0, 0);
			nseg = ($urandom_range(0, 19) == 0) ? $urandom_range(60, 70) : $urandom_range(1, 8);
			for (int i = 0; i < nseg; i++)
				send(rsch_pkg::MODE_LOAD, coord(), coord(), coord(), coord());
			ncast = $urandom_range(1, 6);
			for (int i = 0; i < ncast; i++) begin
				if ($urandom_range(0, 19) == 0)
					send(MODE_UNUSED, int'($urandom), int'($urandom), int'($urandom),
						int'($urandom));
				random_ray();
			end
		end

		s_tvalid <= 1'b0;
		wait (pending == 0);
		repeat (200) @(posedge clk);
		$display("Cast %0d rays (%0d with a hit) over %0d segment loads,", casts, hits, loads);
		$display("with random stalls, one long output hold-off and a full drain.");
		if (fails == 0) begin
			$display("SUCCESS");
		end else begin
			$display("%0d failures", fails);
			$display("FAILURE");
		end
		$finish;
	end

endmodule
